// ===== rtl/lslf_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the line fit block.
package lslf_pkg;

  localparam int DEF_MAX_POINTS = 1024;
  localparam int PT_W           = 16;   // x and y sample width, Q12.4
  localparam int RES_W          = 48;   // slope and intercept width, Q32.16
  localparam int ST_W           = 2;
  localparam int SLOPE_SHIFT    = 16;
  localparam int ICPT_SHIFT     = 12;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_VERT = 2'd1,
    ST_OVF  = 2'd2
  } fit_status_t;

  // Products formed by the shared multiplier, in issue order.
  typedef enum logic [2:0] {
    OP_N_SXX   = 3'd0,
    OP_SX_SX   = 3'd1,
    OP_N_SXY   = 3'd2,
    OP_SX_SY   = 3'd3,
    OP_SY_SXX  = 3'd4,
    OP_SX_SXY  = 3'd5
  } mul_op_t;

  typedef struct packed {
    logic    acc;
    logic    mul_load;
    logic    mul_step;
    logic    mul_save;
    mul_op_t mul_op;
    logic    div_load;
    logic    div_step;
    logic    div_save;
    logic    div_sel;    // 0 slope, 1 intercept
    logic    publish;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf;
    logic den_zero;
  } dp_stat_t;

endpackage

// ===== rtl/lslf_dp.sv =====
// Datapath: running sums, shared serial multiplier, restoring divider and result registers.
module lslf_dp import lslf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic signed [PT_W-1:0]  x_value,
  input  logic signed [PT_W-1:0]  y_value,
  output logic signed [RES_W-1:0] slope,
  output logic signed [RES_W-1:0] intercept,
  output logic [ST_W-1:0]         status
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SX_W  = PT_W + CNT_W;
  localparam int SXX_W = 2 * PT_W - 1 + CNT_W;
  localparam int SXY_W = 2 * PT_W + CNT_W;
  localparam int MW    = SXY_W;
  localparam int PW    = 3 * PT_W + 2 * CNT_W;
  localparam int DW    = PW + ICPT_SHIFT;

  // running sums
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SX_W-1:0]  sx_r, sy_r;
  logic signed [SXX_W-1:0] sxx_r;
  logic signed [SXY_W-1:0] sxy_r;
  logic                    ovf_r;
  logic signed [2*PT_W-1:0] xx, xy;

  assign xx = x_value * x_value;
  assign xy = x_value * y_value;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.publish) begin
      cnt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.acc && !ovf_r) begin
      if (cnt_r >= CNT_W'(MAX_POINTS)) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
        sx_r  <= sx_r + SX_W'(x_value);
        sy_r  <= sy_r + SX_W'(y_value);
        sxx_r <= sxx_r + SXX_W'(xx);
        sxy_r <= sxy_r + SXY_W'(xy);
      end
    end
  end

  // shared shift-add multiplier on magnitudes
  logic signed [MW:0] opa, opb, abs_a, abs_b;
  logic [MW-1:0]      ma_r;
  logic [2*MW-1:0]    prod_r;
  logic               pneg_r;
  logic [MW:0]        psum;
  logic [PW-1:0]      p_mag, p_val;
  logic [PW-1:0]      tmp_r, den_r, num_r, inum_r;

  always_comb begin
    unique case (cmd.mul_op)
      OP_N_SXX: begin
        opa = (MW+1)'(cnt_r);
        opb = (MW+1)'(sxx_r);
      end
      OP_SX_SX: begin
        opa = (MW+1)'(sx_r);
        opb = (MW+1)'(sx_r);
      end
      OP_N_SXY: begin
        opa = (MW+1)'(cnt_r);
        opb = (MW+1)'(sxy_r);
      end
      OP_SX_SY: begin
        opa = (MW+1)'(sx_r);
        opb = (MW+1)'(sy_r);
      end
      OP_SY_SXX: begin
        opa = (MW+1)'(sy_r);
        opb = (MW+1)'(sxx_r);
      end
      OP_SX_SXY: begin
        opa = (MW+1)'(sx_r);
        opb = (MW+1)'(sxy_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign abs_a = opa[MW] ? -opa : opa;
  assign abs_b = opb[MW] ? -opb : opb;
  assign psum  = {1'b0, prod_r[2*MW-1:MW]} + (prod_r[0] ? {1'b0, ma_r} : '0);
  assign p_mag = prod_r[PW-1:0];
  assign p_val = pneg_r ? -p_mag : p_mag;

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_r   <= abs_a[MW-1:0];
      prod_r <= {{MW{1'b0}}, abs_b[MW-1:0]};
      pneg_r <= opa[MW] ^ opb[MW];
    end else if (cmd.mul_step) begin
      prod_r <= {psum, prod_r[MW-1:1]};
    end
    if (cmd.mul_save) begin
      unique case (cmd.mul_op)
        OP_N_SXX, OP_N_SXY, OP_SY_SXX: tmp_r <= p_val;
        OP_SX_SX:  den_r  <= tmp_r - p_val;
        OP_SX_SY:  num_r  <= tmp_r - p_val;
        OP_SX_SXY: inum_r <= tmp_r - p_val;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [PW-1:0]    dsrc, dsrc_mag, den_mag, dmag_r, rem_r;
  logic [DW-1:0]    dvd_r;
  logic [RES_W-1:0] q_r, lim, qres, sres;
  logic             qovf_r, qneg_r, qbit;
  logic [PW:0]      trial, tdiff;
  logic [RES_W-1:0] fit_slope_r, fit_icpt_r;

  assign dsrc     = cmd.div_sel ? inum_r : num_r;
  assign dsrc_mag = dsrc[PW-1] ? -dsrc : dsrc;
  assign den_mag  = den_r[PW-1] ? -den_r : den_r;
  assign trial    = {rem_r, dvd_r[DW-1]};
  assign tdiff    = trial - {1'b0, dmag_r};
  assign qbit     = !tdiff[PW];
  assign lim      = qneg_r ? (RES_W'(1) << (RES_W - 1))
                           : ((RES_W'(1) << (RES_W - 1)) - RES_W'(1));
  assign qres     = (qovf_r || (q_r > lim)) ? lim : q_r;
  assign sres     = qneg_r ? -qres : qres;

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r  <= cmd.div_sel ? (DW'(dsrc_mag) << ICPT_SHIFT)
                            : (DW'(dsrc_mag) << SLOPE_SHIFT);
      dmag_r <= den_mag;
      rem_r  <= '0;
      q_r    <= '0;
      qovf_r <= 1'b0;
      qneg_r <= dsrc[PW-1] ^ den_r[PW-1];
    end else if (cmd.div_step) begin
      dvd_r  <= dvd_r << 1;
      rem_r  <= qbit ? tdiff[PW-1:0] : trial[PW-1:0];
      q_r    <= {q_r[RES_W-2:0], qbit};
      qovf_r <= qovf_r | q_r[RES_W-1];
    end
    if (cmd.div_save) begin
      if (cmd.div_sel) begin
        fit_icpt_r <= sres;
      end else begin
        fit_slope_r <= sres;
      end
    end
  end

  // output payload
  logic                    den_zero;
  logic [RES_W-1:0]        slope_r, icpt_r;
  fit_status_t             status_r;

  assign den_zero = (den_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (ovf_r) begin
        status_r <= ST_OVF;
        slope_r  <= '0;
        icpt_r   <= '0;
      end else if (den_zero) begin
        status_r <= ST_VERT;
        slope_r  <= '0;
        icpt_r   <= '0;
      end else begin
        status_r <= ST_OK;
        slope_r  <= fit_slope_r;
        icpt_r   <= fit_icpt_r;
      end
    end
  end

  assign stat.ovf      = ovf_r;
  assign stat.den_zero = den_zero;
  assign slope         = slope_r;
  assign intercept     = icpt_r;
  assign status        = status_r;

endmodule

// ===== rtl/lslf_ctrl.sv =====
// Controller: sequences accumulation, the six products, both divisions and the result beat.
module lslf_ctrl import lslf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_last_point,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int MW     = 2 * PT_W + CNT_W;
  localparam int DW     = 3 * PT_W + 2 * CNT_W + ICPT_SHIFT;
  localparam int STEP_W = $clog2(DW + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MLOAD = 6'b000010,
    S_MUL   = 6'b000100,
    S_DLOAD = 6'b001000,
    S_DIV   = 6'b010000,
    S_PUB   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  mul_op_t           op_r, op_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              dsel_r, dsel_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    cmd         = '0;
    cmd.mul_op  = op_r;
    cmd.div_sel = dsel_r;
    state_nxt   = state_r;
    op_nxt      = op_r;
    step_nxt    = step_r;
    dsel_nxt    = dsel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (in_last_point) begin
            op_nxt    = OP_N_SXX;
            state_nxt = S_MLOAD;
          end
        end
      end
      S_MLOAD: begin
        // skip the fit on overflow or a zero denominator
        if ((op_r == OP_N_SXX && stat.ovf) || (op_r == OP_N_SXY && stat.den_zero)) begin
          state_nxt = S_PUB;
        end else begin
          cmd.mul_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        if (step_r == STEP_W'(MW)) begin
          cmd.mul_save = 1'b1;
          if (op_r == OP_SX_SXY) begin
            dsel_nxt  = 1'b0;
            state_nxt = S_DLOAD;
          end else begin
            op_nxt    = mul_op_t'(3'(op_r) + 3'd1);
            state_nxt = S_MLOAD;
          end
        end else begin
          cmd.mul_step = 1'b1;
          step_nxt     = step_r + STEP_W'(1);
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (step_r == STEP_W'(DW)) begin
          cmd.div_save = 1'b1;
          if (dsel_r) begin
            state_nxt = S_PUB;
          end else begin
            dsel_nxt  = 1'b1;
            state_nxt = S_DLOAD;
          end
        end else begin
          cmd.div_step = 1'b1;
          step_nxt     = step_r + STEP_W'(1);
        end
      end
      S_PUB: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_N_SXX;
      step_r      <= '0;
      dsel_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      step_r      <= step_nxt;
      dsel_r      <= dsel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/least_squares_line_fit_top.sv =====
// Top level of the least-squares line fit: controller plus datapath.
//
// Input channel (in_valid / in_stall): one (x, y) point in signed Q12.4 per beat;
// in_last_point closes the set. While the block collects points it takes one
// beat every cycle and produces nothing.
// On the closing beat the block runs the fit: six products on one bit-serial
// multiplier of MW bits, then two restoring divisions of a DW-bit dividend,
// with MW = 32 + C, DW = 60 + 2*C and C = clog2(MAX_POINTS + 1). in_stall stays
// high from the closing beat until the result is published. Overflow or a zero
// denominator skips the remaining work and reports early.
// Result channel (out_valid / out_stall): one beat per set with slope and
// intercept in signed Q32.16 (saturated) and a status code. The result sits in
// an output register, so the next set can start while it waits; a second fit
// holds in its final step until the first result is taken.
// Reset (rst_n low, synchronous) clears the sums, the count, the overflow flag
// and the output valid.
module least_squares_line_fit_top import lslf_pkg::*; #(
  parameter int MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [PT_W-1:0]  in_x_value,
  input  logic signed [PT_W-1:0]  in_y_value,
  input  logic                    in_last_point,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [RES_W-1:0] out_slope,
  output logic signed [RES_W-1:0] out_intercept,
  output logic [ST_W-1:0]         out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lslf_ctrl #(
    .MAX_POINTS(MAX_POINTS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_point(in_last_point),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  lslf_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .x_value  (in_x_value),
    .y_value  (in_y_value),
    .slope    (out_slope),
    .intercept(out_intercept),
    .status   (out_status)
  );

endmodule
